[rtl/esd_pkg.sv]
// Shared types, character codes and helpers for the escape sequence decoder.
`default_nettype none

package esd_pkg;

  localparam int LENGTH_BITS_DEF = 16;   // default width of the length counter
  localparam int OUT_LEN_W       = 16;   // width of the reported length
  localparam int FIFO_DEPTH      = 4;    // result buffer entries

  // Character codes
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_7       = 8'h37;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LB      = 8'h62;
  localparam logic [7:0] CH_LC      = 8'h63;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_LN      = 8'h6E;
  localparam logic [7:0] CH_LR      = 8'h72;
  localparam logic [7:0] CH_LT      = 8'h74;
  localparam logic [7:0] CH_LV      = 8'h76;
  localparam logic [7:0] CH_LX      = 8'h78;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_UX      = 8'h58;

  // Control codes produced by the letter escapes
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_VT  = 8'h0B;
  localparam logic [7:0] CODE_FS  = 8'h1C;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } parse_mode_t;

  // One result item
  typedef struct packed {
    logic [7:0]           data;
    logic                 valid;
    logic                 last;
    logic [OUT_LEN_W-1:0] length;
  } res_t;

  // Results of one decoded input byte, handed to the result buffer
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  // {is_hex_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c inside {[CH_0:CH_9]})
      res = {1'b1, 4'(c - CH_0)};
    else if (c inside {[CH_LA:CH_LF]})
      res = {1'b1, 4'(c - CH_LA + 8'd10)};
    else if (c inside {[CH_UA:CH_UF]})
      res = {1'b1, 4'(c - CH_UA + 8'd10)};
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/esd_decode.sv]
// Escape parser: parse state, length counter and per-byte result decode.
`default_nettype none

module esd_decode #(
  parameter int LENGTH_BITS = esd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    item_byte,
  input  wire logic          item_last,
  input  wire logic          adv,        // staged byte is consumed this cycle
  output esd_pkg::push_t     push
);

  esd_pkg::parse_mode_t   mode_r, mode_nxt;
  logic [7:0]             digit_r, digit_nxt;
  logic [1:0]             taken_r, taken_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [LENGTH_BITS-1:0] len0, len1;

  logic [1:0] ne;
  logic [7:0] b0, b1;
  logic [4:0] hx;
  logic       is_oct;
  logic       do_text;
  logic [7:0] acc;

  // saturating lengths after one and two emitted bytes
  assign len0 = (&count_r) ? count_r : count_r + 1'b1;
  assign len1 = (&len0) ? len0 : len0 + 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    digit_nxt = digit_r;
    taken_nxt = taken_r;
    ne        = 2'd0;
    b0        = 8'd0;
    b1        = 8'd0;
    do_text   = 1'b0;
    acc       = 8'd0;
    hx        = esd_pkg::hex_digit(item_byte);
    is_oct    = item_byte inside {[esd_pkg::CH_0:esd_pkg::CH_7]};

    case (mode_r)
      esd_pkg::MODE_TEXT: begin
        do_text = 1'b1;
      end
      esd_pkg::MODE_ESC: begin
        mode_nxt = esd_pkg::MODE_TEXT;
        case (item_byte)
          esd_pkg::CH_LA:      begin b0 = esd_pkg::CODE_BEL; ne = 2'd1; end
          esd_pkg::CH_LB:      begin b0 = esd_pkg::CODE_BS;  ne = 2'd1; end
          esd_pkg::CH_LC:      begin b0 = esd_pkg::CODE_FS;  ne = 2'd1; end
          esd_pkg::CH_LF:      begin b0 = esd_pkg::CODE_FF;  ne = 2'd1; end
          esd_pkg::CH_LN:      begin b0 = esd_pkg::CODE_LF;  ne = 2'd1; end
          esd_pkg::CH_LT:      begin b0 = esd_pkg::CODE_HT;  ne = 2'd1; end
          esd_pkg::CH_LR:      begin b0 = esd_pkg::CODE_CR;  ne = 2'd1; end
          esd_pkg::CH_LV:      begin b0 = esd_pkg::CODE_VT;  ne = 2'd1; end
          esd_pkg::CH_QMARK:   begin b0 = esd_pkg::CH_QMARK; ne = 2'd1; end
          esd_pkg::CH_NEWLINE: begin end  // line continuation
          esd_pkg::CH_LX, esd_pkg::CH_UX: begin
            mode_nxt  = esd_pkg::MODE_HEX;
            digit_nxt = 8'd0;
            taken_nxt = 2'd0;
          end
          default: begin
            if (is_oct) begin
              mode_nxt  = esd_pkg::MODE_OCT;
              digit_nxt = item_byte - esd_pkg::CH_0;
              taken_nxt = 2'd1;
            end else begin
              b0 = item_byte;
              ne = 2'd1;
            end
          end
        endcase
      end
      esd_pkg::MODE_HEX: begin
        if (hx[4]) begin
          digit_nxt = {digit_r[3:0], hx[3:0]};
          taken_nxt = taken_r + 2'd1;
          if (taken_nxt >= 2'd2) begin
            mode_nxt = esd_pkg::MODE_TEXT;
            b0       = digit_nxt;
            ne       = 2'd1;
          end
        end else begin
          mode_nxt = esd_pkg::MODE_TEXT;
          b0       = digit_r;
          ne       = 2'd1;
          do_text  = 1'b1;
        end
      end
      esd_pkg::MODE_OCT: begin
        if (is_oct) begin
          acc       = item_byte - esd_pkg::CH_0;
          digit_nxt = {digit_r[4:0], 3'b000} + acc;
          taken_nxt = taken_r + 2'd1;
          if (taken_nxt >= 2'd3) begin
            mode_nxt = esd_pkg::MODE_TEXT;
            b0       = digit_nxt;
            ne       = 2'd1;
          end
        end else begin
          mode_nxt = esd_pkg::MODE_TEXT;
          b0       = digit_r;
          ne       = 2'd1;
          do_text  = 1'b1;
        end
      end
      default: begin
        mode_nxt = esd_pkg::MODE_TEXT;
      end
    endcase

    // byte handled as plain text (also after a numeric escape ends)
    if (do_text) begin
      if (item_byte == esd_pkg::CH_BSLASH) begin
        mode_nxt = esd_pkg::MODE_ESC;
      end else begin
        if (ne == 2'd0) b0 = item_byte;
        else            b1 = item_byte;
        ne = ne + 2'd1;
      end
    end

    // end of string flushes a pending numeric escape
    if (item_last && (mode_nxt == esd_pkg::MODE_HEX || mode_nxt == esd_pkg::MODE_OCT)) begin
      if (ne == 2'd0) b0 = digit_nxt;
      else            b1 = digit_nxt;
      ne = ne + 2'd1;
    end

    case (ne)
      2'd0:    count_nxt = count_r;
      2'd1:    count_nxt = len0;
      default: count_nxt = len1;
    endcase
  end

  always_comb begin
    push.r0.data   = b0;
    push.r0.valid  = (ne != 2'd0);
    push.r0.last   = item_last && (ne != 2'd2);
    push.r0.length = (ne != 2'd0) ? esd_pkg::OUT_LEN_W'(len0)
                                  : esd_pkg::OUT_LEN_W'(count_r);
    push.r1.data   = b1;
    push.r1.valid  = 1'b1;
    push.r1.last   = item_last;
    push.r1.length = esd_pkg::OUT_LEN_W'(len1);
    // a last byte with nothing decoded still yields one end result
    if (!adv)
      push.count = 2'd0;
    else if (ne == 2'd0 && item_last)
      push.count = 2'd1;
    else
      push.count = ne;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= esd_pkg::MODE_TEXT;
      digit_r <= 8'd0;
      taken_r <= 2'd0;
      count_r <= '0;
    end else if (adv) begin
      if (item_last) begin
        mode_r  <= esd_pkg::MODE_TEXT;
        digit_r <= 8'd0;
        taken_r <= 2'd0;
        count_r <= '0;
      end else begin
        mode_r  <= mode_nxt;
        digit_r <= digit_nxt;
        taken_r <= taken_nxt;
        count_r <= count_nxt;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_last |=> mode_r == esd_pkg::MODE_TEXT && count_r == '0)
    else $error("parse state not cleared after end of string");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item_last |-> push.count != 2'd0)
    else $error("end of string produced no result");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(count_r) && $stable(mode_r))
    else $error("parse state moved without a consumed byte");

endmodule

`default_nettype wire

[rtl/esd_out_fifo.sv]
// Result buffer: takes up to two results per cycle, delivers one per cycle while out_ready is high.
`default_nettype none

module esd_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire esd_pkg::push_t push,
  output logic                room2,    // two free entries
  output logic                out_valid,
  input  wire logic           out_ready,
  output esd_pkg::res_t       out_res
);

  localparam int DEPTH = esd_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  esd_pkg::res_t mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [PW-1:0] wr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= CW'(DEPTH - 2));
  assign wr_p1     = wr_r + 1'b1;
  assign cnt_nxt   = cnt_r + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_r]  <= push.r0;
    if (push.count == 2'd2) mem[wr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(push.count);
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(push.count) <= CW'(DEPTH) - cnt_r)
    else $error("result buffer overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result buffer count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.count == 2'd0 |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("result buffer count wrong after a read");

endmodule

`default_nettype wire

[rtl/escape_sequence_decoder_unit.sv]
// Top level of the C string escape sequence decoder.
`default_nettype none

// Decodes a C-style escaped string arriving one byte per transfer on the
// in_ stream (in_tlast on the final byte) and delivers decoded bytes on the
// out_ stream. Plain bytes pass through; a backslash starts an escape
// (letter codes a b c f n t r v ?, line continuation, \x with up to two hex
// digits, up to three octal digits kept to 8 bits). A numeric escape cut
// short by another byte emits its value and handles that byte as text, so
// one input transfer yields zero, one or two results; at end of string a
// pending numeric value is flushed and a trailing lone backslash is dropped.
// The final result of each string has out_tlast set and carries the decoded
// length (saturating at 2^LENGTH_BITS-1, reported in 16 bits); if the last
// byte decodes to nothing, one result with out_tuser low and data 0 still
// marks the end. Timing: one input transfer per clock while the result
// buffer has room; a result passes through the input stage register and
// then the result buffer. The 4-entry result buffer must hold two free
// entries for the staged byte to move on, so with out_tready held high only
// runs of two-result bytes slow the input side, to the one-result-per-cycle output.
// Parse state resets after every end of string.

module escape_sequence_decoder_unit #(
  parameter int LENGTH_BITS = esd_pkg::LENGTH_BITS_DEF   // 8..32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] in_byte
  input  wire logic        in_tlast,    // in_last
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic             out_tuser,   // byte_valid
  output logic             out_tlast    // out_end
);

  // input stage register
  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  logic           room2;
  logic           adv;
  esd_pkg::push_t push;
  esd_pkg::res_t  head;

  // staged byte moves into the buffer only when both results would fit
  assign adv       = stg_valid_r && room2;
  assign in_tready = !stg_valid_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  esd_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (stg_byte_r),
    .item_last (stg_last_r),
    .adv       (adv),
    .push      (push)
  );

  esd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tdata = {head.length, head.data};
  assign out_tuser = head.valid;
  assign out_tlast = head.last;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the escape sequence decoder unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import esd_pkg::*;

  localparam int LEN_W        = LENGTH_BITS_DEF;
  localparam int RAND_ITEMS   = 520;
  localparam int HOLD_CYCLES  = 300;                // receiver hold-off, fills the result buffer
  localparam int DRAIN_CYCLES = 10;                 // two-stage pipe, with margin
  localparam int STALL_LIMIT  = 2000;               // cycles with no transfer before giving up

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        in_tlast;    // in_last
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [7:0] out_byte, [23:8] out_length
  logic        out_tuser;   // byte_valid
  logic        out_tlast;   // out_end

  escape_sequence_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // One row of the directed part; when pinned, the single result is given here
  // instead of being worked out by the decoder model below.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       pinned;
    res_t       want;
  } row_t;

  // Decoder model state, cleared after every end of string
  parse_mode_t      mode;
  logic [7:0]       acc;
  logic [1:0]       ndig;
  logic [LEN_W-1:0] len_count;

  res_t       step_res [2];   // results of the byte just decoded
  int         step_n;
  res_t       decoded_q [$];  // decoded bytes still owed by the block
  row_t       rows [$];
  logic [7:0] str_q [$];      // string under construction

  string hexchars = "0123456789abcdefABCDEF";
  string escchars = "abcfntrv?\nq";   // letter escapes, line continuation, one plain pass-through

  int n_fail;
  int idle_cycles;
  bit full_speed;   // no gaps on either side
  bit hold_req;     // ask the receiver for its one long hold-off
  bit holding;      // receiver is in that hold-off; sender keeps offering back to back

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Append one decoded byte; the count sticks at its top value.
  task automatic put_byte(input logic [7:0] b);
    res_t r;
    if (step_n > 1) return;
    if (len_count != '1) len_count = len_count + 1'b1;
    r.data   = b;
    r.valid  = 1'b1;
    r.last   = 1'b0;
    r.length = 16'(len_count);
    step_res[step_n] = r;
    step_n++;
  endtask

  task automatic take_text(input logic [7:0] c);
    if (c == CH_BSLASH) mode = MODE_ESC;
    else put_byte(c);
  endtask

  // Byte right after a backslash
  task automatic take_escape(input logic [7:0] c);
    mode = MODE_TEXT;
    case (c)
      CH_LA:      put_byte(CODE_BEL);
      CH_LB:      put_byte(CODE_BS);
      CH_LC:      put_byte(CODE_FS);
      CH_LF:      put_byte(CODE_FF);
      CH_LN:      put_byte(CODE_LF);
      CH_LT:      put_byte(CODE_HT);
      CH_LR:      put_byte(CODE_CR);
      CH_LV:      put_byte(CODE_VT);
      CH_QMARK:   put_byte(CH_QMARK);
      CH_NEWLINE: ;   // line continuation, nothing out
      CH_LX, CH_UX: begin
        mode = MODE_HEX;
        acc  = 8'h00;
        ndig = 2'd0;
      end
      default: begin
        if (c >= CH_0 && c <= CH_7) begin
          mode = MODE_OCT;
          acc  = c - CH_0;
          ndig = 2'd1;
        end else begin
          put_byte(c);
        end
      end
    endcase
  endtask

  // Decode one input byte into step_res[0 .. step_n-1].
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    int   hv;
    res_t r;
    step_n = 0;
    case (mode)
      MODE_TEXT: take_text(c);
      MODE_ESC:  take_escape(c);
      MODE_HEX: begin
        hv = hex_val(c);
        if (hv >= 0) begin
          acc  = {acc[3:0], 4'(hv)};
          ndig = ndig + 2'd1;
          if (ndig >= 2'd2) begin
            mode = MODE_TEXT;
            put_byte(acc);
          end
        end else begin
          // non-digit closes the escape, then counts as text
          mode = MODE_TEXT;
          put_byte(acc);
          take_text(c);
        end
      end
      default: begin
        if (c >= CH_0 && c <= CH_7) begin
          acc  = {acc[4:0], 3'b000} + (c - CH_0);
          ndig = ndig + 2'd1;
          if (ndig >= 2'd3) begin
            mode = MODE_TEXT;
            put_byte(acc);
          end
        end else begin
          mode = MODE_TEXT;
          put_byte(acc);
          take_text(c);
        end
      end
    endcase
    if (fin) begin
      // pending numeric value is flushed; a lone backslash just vanishes
      if (mode == MODE_HEX || mode == MODE_OCT) put_byte(acc);
      if (step_n == 0) begin
        r.data      = 8'h00;
        r.valid     = 1'b0;
        r.last      = 1'b0;
        r.length    = 16'(len_count);
        step_res[0] = r;
        step_n      = 1;
      end
      step_res[step_n-1].last = 1'b1;
      mode      = MODE_TEXT;
      acc       = 8'h00;
      ndig      = 2'd0;
      len_count = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte from a falling edge, wait for the transfer, log what it owes.
  // Returns at the next falling edge with tvalid still high.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic pinned,
                           input res_t want);
    int gap;
    gap = (full_speed || holding || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, fin);   // model state moves on even for pinned rows
    if (pinned) begin
      decoded_q.push_back(want);
    end else begin
      for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
    end
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin, input logic pinned,
                         input logic [7:0] d, input logic v, input logic l,
                         input logic [15:0] len);
    row_t r;
    r.b           = b;
    r.fin         = fin;
    r.pinned      = pinned;
    r.want.data   = d;
    r.want.valid  = v;
    r.want.last   = l;
    r.want.length = len;
    rows.push_back(r);
  endtask

  // Random string built from tokens, then cut at a random length so that
  // strings also end inside escapes.
  task automatic build_string();
    int target;
    int kind;
    int k;
    logic [7:0] b;
    str_q.delete();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
    while (str_q.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        b = $urandom_range(0, 255);
        if (b == CH_BSLASH) b = 8'h5D;
        str_q.push_back(b);
      end else if (kind < 55) begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(escchars[$urandom_range(0, escchars.len() - 1)]);
      end else if (kind < 70) begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        k = $urandom_range(0, 3);
        repeat (k) str_q.push_back(hexchars[$urandom_range(0, hexchars.len() - 1)]);
      end else if (kind < 85) begin
        str_q.push_back(CH_BSLASH);
        k = $urandom_range(1, 4);
        repeat (k) str_q.push_back(8'(CH_0 + $urandom_range(0, 7)));
      end else if (kind < 92) begin
        // digit-like text, e.g. an 8 or 9 cutting an octal escape short
        str_q.push_back(hexchars[$urandom_range(0, hexchars.len() - 1)]);
      end else begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (str_q.size() > target) void'(str_q.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stim
    int   sent_rand;
    bit   held;
    res_t none;

    none      = '0;
    sent_rand = 0;
    held      = 1'b0;
    n_fail    = 0;
    full_speed = 1'b0;
    hold_req  = 1'b0;
    holding   = 1'b0;
    mode      = MODE_TEXT;
    acc       = 8'h00;
    ndig      = 2'd0;
    len_count = '0;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: field extremes, escapes of each kind, end-of-string cases.
    add_row(8'h01,      1'b0, 1'b1, 8'h01, 1'b1, 1'b0, 16'd1);
    add_row(8'hFF,      1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd2);
    add_row(8'h00,      1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 16'd3);   // zero byte just passes
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_LN,      1'b0, 1'b1, CODE_LF, 1'b1, 1'b0, 16'd1);
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_NEWLINE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // continuation
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_LC,      1'b0, 1'b1, CODE_FS, 1'b1, 1'b0, 16'd2);
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("q",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // unknown escape letter
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_LX,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("G",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // hex escape with no digits
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_UX,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("f",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("F",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_7,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_7,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row(CH_7,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // octal 777 wraps to 8 bits
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("1",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("9",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // non-octal digit ends it
    add_row(CH_BSLASH,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    add_row("5",        1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);   // end flushes pending octal
    add_row(CH_BSLASH,  1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0);   // lone backslash at end

    foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].pinned, rows[i].want);

    // Sender pause: hold off until every owed result has been delivered.
    in_tvalid <= 1'b0;
    wait (decoded_q.size() == 0);
    @(negedge clk);

    // Random strings, mostly well formed with random content.
    while (sent_rand < RAND_ITEMS) begin
      full_speed = ($urandom_range(0, 7) == 0);
      if (!held && sent_rand >= 150) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      build_string();
      foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1, 1'b0, none);
      sent_rand += str_q.size();
    end

    in_tvalid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random tready with one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : sink
    int idle;
    idle       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long stall counted here; the result buffer fills and in_tready drops
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
        out_tready <= 1'b1;
      end else if (idle > 0) begin
        out_tready <= 1'b0;
        idle--;
      end else begin
        out_tready <= 1'b1;
        if (!full_speed && $urandom_range(0, 99) < 25) idle = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each transfer against the oldest owed result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result transfer: byte %0h valid %0b end %0b length %0d",
               out_tdata[7:0], out_tuser, out_tlast, out_tdata[23:8]);
        n_fail++;
      end else begin
        w = decoded_q.pop_front();
        if (out_tdata[7:0] !== w.data) begin
          $error("out_byte: expected %02h, got %02h", w.data, out_tdata[7:0]);
          n_fail++;
        end
        if (out_tuser !== w.valid) begin
          $error("byte_valid: expected %0b, got %0b", w.valid, out_tuser);
          n_fail++;
        end
        if (out_tlast !== w.last) begin
          $error("out_end: expected %0b, got %0b", w.last, out_tlast);
          n_fail++;
        end
        if (out_tdata[23:8] !== w.length) begin
          $error("out_length: expected %0d, got %0d", w.length, out_tdata[23:8]);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: too long with no transfer on either side means a hang.
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
